[src/radr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radr_pkg: shared types and constants
// Field widths, register codes, reset values and fixed-point constants of the
// rolling average deviation reward block.
// ----------------------------------------------------------------------------
package radr_pkg;

	localparam int WINDOW_MAX_DEF = 64;

	localparam int SAMPLE_W   = 32;
	localparam int WIN_CFG_W  = 7;
	localparam int COEF_W     = 16;
	localparam int MULT_W     = 32;
	localparam int MULT_FRAC  = 16;
	localparam int REWARD_W   = 48;
	localparam int PROD_SHIFT = 8;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_FIELD_W = REWARD_W + 2 * SAMPLE_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	localparam logic [WIN_CFG_W-1:0]    WIN_RESET   = 7'd64;
	localparam logic signed [COEF_W-1:0] GOOD_RESET = 16'sh0000;
	localparam logic signed [COEF_W-1:0] BAD_RESET  = 16'shFE00;

	localparam logic [SAMPLE_W-1:0] SPECIAL_AVG = 32'd999;
	localparam logic [MULT_W-1:0]   MULT_ONE    = 32'h0001_0000;
	localparam logic [MULT_W-1:0]   MULT_SAT    = 32'hFFFF_FFFF;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_GOOD_COEF   = 2'd1,
		REG_BAD_COEF    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

[src/radr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module radr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[src/radr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radr_div: shared radix-2 restoring divider
// Unsigned division, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module radr_div #(
	parameter int DIV_W  = 48,
	parameter int DVSR_W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIV_W-1:0]      dividend,
	input  wire logic [DVSR_W-1:0]     divisor,
	output logic      [DIV_W-1:0]      quotient,
	output radr_pkg::div_stat_t        stat
);
	import radr_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  dvd_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVSR_W:0] trial;
	logic [DVSR_W:0] trial_sub;
	logic            ge;

	assign trial     = {rem_q, dvd_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, dvsr_q};
	assign ge        = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvsr_q <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial_sub[DVSR_W-1:0] : trial[DVSR_W-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

endmodule
`default_nettype wire

[src/rolling_average_deviation_reward.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_average_deviation_reward: moving average relative deviation reward
// Keeps recent loop-time samples in a ring, averages them and turns the
// relative deviation of the newest sample into a signed Q16 reward.
// ----------------------------------------------------------------------------
// One sample at a time: the block takes a sample, updates the ring and the
// running sum, divides the sum by the fill count on the shared radix-2
// divider, then divides the Q16 deviation by the sample or the average on the
// same divider, multiplies by the Q8.8 coefficient and presents the result.
// The divider is DIV_W bits wide, the wider of the running sum width and 48.
// When the average is 0 or 999, or a zero sample meets a nonzero average, the
// second division is skipped. The input is ready again while the previous
// result waits in the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rolling_average_deviation_reward #(
	parameter int WINDOW_MAX = radr_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [radr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // loop_time
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// reward_value, window_average, sample_echo, is_good, zero pad
	output logic      [radr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  wire logic                              cfg_wr_en,
	input  wire logic [radr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [radr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import radr_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_W + PTR_W;
	localparam int NUM_W  = SAMPLE_W + MULT_FRAC;
	localparam int DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int CMP_W  = (FILL_W > WIN_CFG_W) ? FILL_W : WIN_CFG_W;
	localparam int PROD_W = MULT_W + 1 + COEF_W;

	localparam logic [CMP_W-1:0]  WIN_MAX_C  = CMP_W'(WINDOW_MAX);
	localparam logic [FILL_W-1:0] WIN_MAX_F  = FILL_W'(WINDOW_MAX);
	localparam logic [FILL_W:0]   WIN_MAX_E  = (FILL_W + 1)'(WINDOW_MAX);
	localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(WINDOW_MAX - 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_LOAD  = 10'b00_0000_0010,
		S_ADD   = 10'b00_0000_0100,
		S_DIVA  = 10'b00_0000_1000,
		S_WAITA = 10'b00_0001_0000,
		S_DIVB  = 10'b00_0010_0000,
		S_WAITB = 10'b00_0100_0000,
		S_MUL   = 10'b00_1000_0000,
		S_OUT   = 10'b01_0000_0000,
		S_SPARE = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [WIN_CFG_W-1:0]     win_size_q;
	logic signed [COEF_W-1:0] good_coef_q;
	logic signed [COEF_W-1:0] bad_coef_q;

	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [SAMPLE_W-1:0]      x_q;
	logic                     drop_q;
	logic [SAMPLE_W-1:0]      avg_q;
	logic                     good_q;
	logic [MULT_W-1:0]        mult_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [CMP_W-1:0]  win_cmp;
	logic [FILL_W-1:0] win_use;
	logic              drop;
	logic [FILL_W:0]   wp_ext;
	logic [FILL_W:0]   fill_ext;
	logic [FILL_W:0]   old_ext;
	logic [PTR_W-1:0]  old_addr;
	logic              in_xfer;
	logic              out_load;
	logic [SAMPLE_W-1:0] rd_data;

	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [SAMPLE_W-1:0] div_divisor;
	logic [DIV_W-1:0]    div_quot;
	div_stat_t           div_stat;

	logic [SAMPLE_W-1:0]      q_avg;
	logic [SAMPLE_W-1:0]      dev;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [PROD_W-1:0] prod_sh;
	logic [REWARD_W-1:0]      reward;

	// window in use and oldest held entry
	assign win_cmp = CMP_W'(win_size_q);
	always_comb begin
		if (win_size_q == '0) begin
			win_use = FILL_W'(1);
		end else if (win_cmp > WIN_MAX_C) begin
			win_use = WIN_MAX_F;
		end else begin
			win_use = win_cmp[FILL_W-1:0];
		end
	end

	assign drop     = (fill_q >= win_use) && (fill_q != '0);
	assign wp_ext   = (FILL_W + 1)'(wp_q);
	assign fill_ext = (FILL_W + 1)'(fill_q);
	assign old_ext  = (wp_ext >= fill_ext) ? (wp_ext - fill_ext)
	                                       : (wp_ext + WIN_MAX_E - fill_ext);
	assign old_addr = old_ext[PTR_W-1:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	radr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == S_LOAD),
		.wr_addr (wp_q),
		.wr_data (x_q),
		.rd_en   (in_xfer),
		.rd_addr (old_addr),
		.rd_data (rd_data)
	);

	// divider operands
	assign dev       = good_q ? (avg_q - x_q) : (x_q - avg_q);
	assign div_start = (state_q == S_DIVA) || (state_q == S_DIVB);
	always_comb begin
		if (state_q == S_DIVB) begin
			div_dividend = DIV_W'({dev, {MULT_FRAC{1'b0}}});
			div_divisor  = good_q ? x_q : avg_q;
		end else begin
			div_dividend = DIV_W'(sum_q);
			div_divisor  = SAMPLE_W'(fill_q);
		end
	end

	radr_div #(
		.DIV_W  (DIV_W),
		.DVSR_W (SAMPLE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	assign q_avg    = div_quot[SAMPLE_W-1:0];
	assign coef_sel = good_q ? good_coef_q : bad_coef_q;
	assign prod_sh  = prod_q >>> PROD_SHIFT;
	assign reward   = prod_sh[REWARD_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q  <= WIN_RESET;
			good_coef_q <= GOOD_RESET;
			bad_coef_q  <= BAD_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WINDOW_SIZE: win_size_q  <= cfg_wdata[WIN_CFG_W-1:0];
				REG_GOOD_COEF:   good_coef_q <= cfg_wdata[COEF_W-1:0];
				REG_BAD_COEF:    bad_coef_q  <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (drop_q) begin
						sum_q  <= sum_q - SUM_W'(rd_data);
						fill_q <= fill_q - FILL_W'(1);
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q   <= sum_q + SUM_W'(x_q);
					fill_q  <= fill_q + FILL_W'(1);
					wp_q    <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
					state_q <= S_DIVA;
				end
				S_DIVA: state_q <= S_WAITA;
				S_WAITA: begin
					if (div_stat.done) begin
						if (q_avg == '0 || q_avg == SPECIAL_AVG ||
						    (x_q == '0)) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DIVB;
						end
					end
				end
				S_DIVB: state_q <= S_WAITB;
				S_WAITB: begin
					if (div_stat.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-sample datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q    <= s_axis_tdata[SAMPLE_W-1:0];
			drop_q <= drop;
		end
		if (state_q == S_WAITA && div_stat.done) begin
			avg_q  <= q_avg;
			good_q <= x_q <= q_avg;
			if (q_avg == '0 || q_avg == SPECIAL_AVG) begin
				mult_q <= MULT_ONE;
			end else begin
				mult_q <= MULT_SAT;
			end
		end
		if (state_q == S_WAITB && div_stat.done) begin
			mult_q <= (|div_quot[DIV_W-1:MULT_W]) ? MULT_SAT : div_quot[MULT_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= $signed({1'b0, mult_q}) * coef_sel;
		end
		if (out_load) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, good_q, x_q, avg_q, reward};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_MAX_F)
		else $error("fill count beyond ring depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PTR_LAST)
		else $error("write pointer beyond ring depth");

	a_avg_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAITA) && div_stat.done |-> div_quot[DIV_W-1:SAMPLE_W] == '0)
		else $error("average wider than a sample");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == S_IDLE) && out_valid_q)
		else $error("result transfer lost");

endmodule
`default_nettype wire
